// ----- rtl/depth_key_sorter_assert.svh -----
// ----------------------------------------------------------------------------
// Depth key sorter assertion macros
// Concurrent checks, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef DEPTH_KEY_SORTER_ASSERT_SVH
`define DEPTH_KEY_SORTER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define DKS_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);
// Next-cycle implication.
`define DKS_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);
`else
`define DKS_ASSERT_IMPL(label, clk, rst, pre, post, msg)
`define DKS_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif

`endif

// ----- rtl/dks_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth key sorter package
// Sizes, entry types and cell operation codes shared by the sorter files.
// ----------------------------------------------------------------------------
package dks_pkg;

   localparam int MAX_ITEMS  = 64;   // cells in the chain, 2 .. 1024
   localparam int KEY_BITS   = 32;   // stored key width, 8 .. 64
   localparam int DEPTH_BITS = 32;   // key width on the ports
   localparam int TAG_BITS   = 6;

   typedef logic signed [KEY_BITS-1:0] key_type;

   typedef struct packed {
      logic                valid;
      key_type             key;
      logic [TAG_BITS-1:0] tag;
   } entry_type;

   // What a cell hands to its right neighbor.
   typedef struct packed {
      entry_type entry;
      logic      gt;     // cell holds a key greater than the incoming one
   } link_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT
   } cell_mode_type;

endpackage

// ----- rtl/dks_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth key sorter channels
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
interface dks_req_if import dks_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [DEPTH_BITS-1:0] depth_key;
   logic [TAG_BITS-1:0]   item_tag;
   logic                  last_item;

   modport source (output valid, depth_key, item_tag, last_item, input ready);
   modport sink   (input valid, depth_key, item_tag, last_item, output ready);
endinterface

interface dks_rsp_if import dks_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [TAG_BITS-1:0]   sorted_tag;
   logic [DEPTH_BITS-1:0] sorted_key;
   logic                  last_result;
   logic                  overflowed;

   modport source (output valid, sorted_tag, sorted_key, last_result, overflowed,
                   input ready);
   modport sink   (input valid, sorted_tag, sorted_key, last_result, overflowed,
                   output ready);
endinterface

// ----- rtl/dks_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth key sorter cell
// One slot of the insertion chain: compares, takes the new key or shifts.
// ----------------------------------------------------------------------------
module dks_cell import dks_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cell_mode_type       mode,
   input  key_type             new_key,
   input  logic [TAG_BITS-1:0] new_tag,
   input  link_type            left_link,
   input  entry_type           right_entry,
   output link_type            link
);

   logic                valid_ff, valid_in;
   key_type             key_ff, key_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic                gt;

   assign gt = valid_ff && ($signed(key_ff) > $signed(new_key));

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      tag_in   = tag_ff;
      unique case (mode)
         CELL_HOLD: begin
         end
         CELL_INSERT: begin
            if (left_link.gt) begin
               // make room: take the left neighbor's entry
               valid_in = left_link.entry.valid;
               key_in   = left_link.entry.key;
               tag_in   = left_link.entry.tag;
            end else if (gt || (!valid_ff && left_link.entry.valid)) begin
               valid_in = 1'b1;
               key_in   = new_key;
               tag_in   = new_tag;
            end
         end
         CELL_SHIFT: begin
            valid_in = right_entry.valid;
            key_in   = right_entry.key;
            tag_in   = right_entry.tag;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

   assign link.entry.valid = valid_ff;
   assign link.entry.key   = key_ff;
   assign link.entry.tag   = tag_ff;
   assign link.gt          = gt;

endmodule

// ----- rtl/depth_key_sorter.sv -----
`timescale 1ns / 1ps
// Load: one request per cycle, each placed into the cell chain in the cycle it is accepted.
// Drain: the first result is valid the cycle after the last request; one result per cycle
// while the receiver is ready. No request enters during drain.
// Results leave through the single output port at the head of the chain.
// Reset (synchronous) empties every cell and clears the overflow flag; key and tag bits keep
// whatever they held.
// ----------------------------------------------------------------------------
// Depth key sorter
// Stable ascending sort of (depth key, tag) pairs through an insertion chain.
// ----------------------------------------------------------------------------
`include "depth_key_sorter_assert.svh"

module depth_key_sorter import dks_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   dks_req_if.sink  req_if,
   dks_rsp_if.source rsp_if
);

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   state_type            state_ff, state_in;
   logic                 ovf_ff, ovf_in;
   cell_mode_type        mode;
   key_type              new_key;
   link_type             links [MAX_ITEMS];
   logic [MAX_ITEMS-1:0] valid_vec;
   logic                 full;
   logic                 req_fire;
   logic                 rsp_fire;
   logic                 last_out;

   // Head of the chain looks like a valid entry that is never greater.
   localparam link_type HEAD_LINK = '{entry: '{valid: 1'b1, key: '0, tag: '0}, gt: 1'b0};

   // Take the low KEY_BITS of the key, sign extended where the store is wider.
   assign new_key  = KEY_BITS'($signed(req_if.depth_key));

   assign full     = links[MAX_ITEMS-1].entry.valid;
   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_fire = rsp_if.valid && rsp_if.ready;
   assign last_out = !links[1].entry.valid;

   // Insert on an accepted request unless the chain is full (drop it then);
   // advance the chain toward the head on each taken result.
   always_comb begin
      if (req_fire && !full) begin
         mode = CELL_INSERT;
      end else if (rsp_fire) begin
         mode = CELL_SHIFT;
      end else begin
         mode = CELL_HOLD;
      end
   end

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      link_type  left_link;
      entry_type right_entry;

      if (i == 0) begin : g_head
         assign left_link = HEAD_LINK;
      end else begin : g_body
         assign left_link = links[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_mid
         assign right_entry = links[i+1].entry;
      end

      dks_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .mode        (mode),
         .new_key     (new_key),
         .new_tag     (req_if.item_tag),
         .left_link   (left_link),
         .right_entry (right_entry),
         .link        (links[i])
      );

      assign valid_vec[i] = links[i].entry.valid;
   end

   // Close the set on the last request; return to load after its last result.
   always_comb begin
      state_in = state_ff;
      ovf_in   = ovf_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (full) begin
                  ovf_in = 1'b1;
               end
               if (req_if.last_item) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_fire && last_out) begin
               state_in = ST_LOAD;
               ovf_in   = 1'b0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign req_if.ready       = (state_ff == ST_LOAD);
   assign rsp_if.valid       = (state_ff == ST_DRAIN);
   assign rsp_if.sorted_tag  = links[0].entry.tag;
   assign rsp_if.sorted_key  = DEPTH_BITS'(links[0].entry.key);
   assign rsp_if.last_result = last_out;
   assign rsp_if.overflowed  = ovf_ff;

   // Occupied cells always form a prefix of the chain.
   `DKS_ASSERT_IMPL(a_prefix, clock, reset, 1'b1, ((valid_vec >> 1) & ~valid_vec) == '0,
                    "occupied cells are not contiguous")
   // Drain never presents an empty head cell.
   `DKS_ASSERT_IMPL(a_head_valid, clock, reset, state_ff == ST_DRAIN, links[0].entry.valid,
                    "drain with empty head cell")
   // The last result empties the chain.
   `DKS_ASSERT_NEXT(a_drained, clock, reset, rsp_fire && last_out,
                    valid_vec == '0 && state_ff == ST_LOAD && !ovf_ff,
                    "chain not empty after last result")

endmodule
